// ===== hw/rtl/mstb_pkg.sv =====
// Shared constants for the millisecond timer bank.
package mstb_pkg;

  localparam int NUM_TIMERS = 3;

  localparam int MODE_W  = 3;
  localparam int TIMER_W = 2;
  localparam int TIME_W  = 16;

  localparam logic [TIME_W-1:0]  MS_TOP_RESET = TIME_W'(11999);
  localparam logic [TIMER_W-1:0] TIMER_NONE   = TIMER_W'(NUM_TIMERS);

  localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INIT    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DEINIT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_START   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_STOP    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_TOGGLE  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_ELAPSED = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RUNNING = 3'd7;

  typedef logic [TIME_W-1:0] time_val_t;

endpackage

// ===== hw/rtl/millisecond_timer_bank.sv =====
// Bank of millisecond timers with timeouts, driven by tick and command transfers.
//
//   channel  handshake             payload
//   in       in_valid / in_ready   mode, timer_select, timeout_value
//   out      out_valid / out_ready assigned_timer, answer_flag, accepted
//   cfg      cfg_valid / cfg_ready cfg_data (ms_top_value)
//
// One item per cycle: each transfer updates the timer state and loads the result
// register in the cycle it is accepted; the result shows in the next cycle.
// in_ready is high whenever the result register is empty or being drained.
// A stalled out channel holds the result and blocks new input until it is taken.
// Synchronous reset clears all timers and sets ms_top_value to 11999.
module millisecond_timer_bank (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [mstb_pkg::MODE_W-1:0]  mode,
  input  logic [mstb_pkg::TIMER_W-1:0] timer_select,
  input  logic [mstb_pkg::TIME_W-1:0]  timeout_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mstb_pkg::TIMER_W-1:0] assigned_timer,
  output logic                         answer_flag,
  output logic                         accepted,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mstb_pkg::TIME_W-1:0]  cfg_data
);

  localparam int N = mstb_pkg::NUM_TIMERS;

  mstb_pkg::time_val_t ms_top;
  logic [N-1:0]        reserved;
  logic [N-1:0]        running;
  mstb_pkg::time_val_t timeout  [N];
  mstb_pkg::time_val_t ms_count [N];
  mstb_pkg::time_val_t prescale [N];

  logic [N-1:0]        reserved_next;
  logic [N-1:0]        running_next;
  mstb_pkg::time_val_t timeout_next  [N];
  mstb_pkg::time_val_t ms_count_next [N];
  mstb_pkg::time_val_t prescale_next [N];

  logic [mstb_pkg::TIMER_W-1:0] res_assigned;
  logic                         res_flag;
  logic                         res_acc;
  logic                         sel_ok;
  logic                         found;
  logic                         in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    reserved_next = reserved;
    running_next  = running;
    timeout_next  = timeout;
    ms_count_next = ms_count;
    prescale_next = prescale;
    res_assigned  = mstb_pkg::TIMER_NONE;
    res_flag      = 1'b0;
    res_acc       = 1'b0;
    found         = 1'b0;
    sel_ok        = 1'b0;
    if (int'(timer_select) < N) begin
      sel_ok = reserved[timer_select];
    end
    unique case (mode)
      mstb_pkg::MODE_TICK: begin
        res_acc = 1'b1;
        for (int t = 0; t < N; t++) begin
          if (reserved[t] && running[t]) begin
            if (prescale[t] == ms_top) begin
              prescale_next[t] = '0;
              if (ms_count[t] != '1) begin
                ms_count_next[t] = ms_count[t] + 1'b1;
              end
            end else begin
              prescale_next[t] = prescale[t] + 1'b1;
            end
          end
        end
      end
      mstb_pkg::MODE_INIT: begin
        if (timeout_value != '0) begin
          for (int t = 0; t < N; t++) begin
            if (!found && !reserved[t]) begin
              found            = 1'b1;
              reserved_next[t] = 1'b1;
              running_next[t]  = 1'b0;
              timeout_next[t]  = timeout_value;
              ms_count_next[t] = '0;
              prescale_next[t] = '0;
              res_assigned     = mstb_pkg::TIMER_W'(t);
              res_acc          = 1'b1;
            end
          end
        end
      end
      mstb_pkg::MODE_DEINIT: begin
        if (sel_ok) begin
          res_acc                       = 1'b1;
          reserved_next[timer_select]   = 1'b0;
          running_next[timer_select]    = 1'b0;
          timeout_next[timer_select]    = '0;
          ms_count_next[timer_select]   = '0;
          prescale_next[timer_select]   = '0;
        end
      end
      mstb_pkg::MODE_START: begin
        if (sel_ok) begin
          res_acc                     = 1'b1;
          running_next[timer_select]  = 1'b1;
          ms_count_next[timer_select] = '0;
          prescale_next[timer_select] = '0;
        end
      end
      mstb_pkg::MODE_STOP: begin
        if (sel_ok) begin
          res_acc                    = 1'b1;
          running_next[timer_select] = 1'b0;
        end
      end
      mstb_pkg::MODE_TOGGLE: begin
        if (sel_ok) begin
          res_acc = 1'b1;
          if (running[timer_select]) begin
            running_next[timer_select] = 1'b0;
          end else begin
            running_next[timer_select]  = 1'b1;
            ms_count_next[timer_select] = '0;
            prescale_next[timer_select] = '0;
          end
        end
      end
      mstb_pkg::MODE_ELAPSED: begin
        if (sel_ok) begin
          res_acc = 1'b1;
          if (running[timer_select] &&
              timeout[timer_select] <= ms_count[timer_select]) begin
            ms_count_next[timer_select] = '0;
            res_flag                    = 1'b1;
          end
        end
      end
      mstb_pkg::MODE_RUNNING: begin
        if (sel_ok) begin
          res_acc  = 1'b1;
          res_flag = running[timer_select];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ms_top   <= mstb_pkg::MS_TOP_RESET;
      reserved <= '0;
      running  <= '0;
      for (int t = 0; t < N; t++) begin
        timeout[t]  <= '0;
        ms_count[t] <= '0;
        prescale[t] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        ms_top <= cfg_data;
      end
      if (in_fire) begin
        reserved <= reserved_next;
        running  <= running_next;
        timeout  <= timeout_next;
        ms_count <= ms_count_next;
        prescale <= prescale_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      assigned_timer <= res_assigned;
      answer_flag    <= res_flag;
      accepted       <= res_acc;
    end
  end

`ifndef ASSERT_OFF
  logic [N-1:0] tmo_zero;

  always_comb begin
    for (int t = 0; t < N; t++) begin
      tmo_zero[t] = (timeout[t] == '0);
    end
  end

  a_run_needs_rsv: assert property (@(posedge clk) disable iff (rst)
    (running & ~reserved) == '0)
    else $error("running timer that is not reserved");

  a_rsv_tmo: assert property (@(posedge clk) disable iff (rst)
    (reserved & tmo_zero) == '0 && (~reserved & ~tmo_zero) == '0)
    else $error("timeout does not match reserved state");

  a_fire_result: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted item gave no result");

  a_tick_acc: assert property (@(posedge clk) disable iff (rst)
    in_fire && mode == mstb_pkg::MODE_TICK |=> accepted && answer_flag == 1'b0)
    else $error("tick result wrong");

  a_flag_acc: assert property (@(posedge clk) disable iff (rst)
    out_valid && answer_flag |-> accepted)
    else $error("answer without accepted command");
`endif

endmodule

// ===== bench/millisecond_timer_bank_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the millisecond timer bank: shadow timer state, scored transfers.
module millisecond_timer_bank_test;

  localparam mstb_pkg::time_val_t COUNT_MAX    = '1;
  localparam int                  REPORT_LINES = 40;

  typedef struct packed {
    logic [mstb_pkg::TIMER_W-1:0] slot;
    logic                         flag;
    logic                         ok;
  } timer_reply_t;

  class timer_bank_shadow;
    bit                  reserved    [mstb_pkg::NUM_TIMERS];
    bit                  running     [mstb_pkg::NUM_TIMERS];
    mstb_pkg::time_val_t tmo_store   [mstb_pkg::NUM_TIMERS];
    mstb_pkg::time_val_t ms_count    [mstb_pkg::NUM_TIMERS];
    mstb_pkg::time_val_t prescale    [mstb_pkg::NUM_TIMERS];
    mstb_pkg::time_val_t top_value;
    timer_reply_t        replies_due [$];
    int                  mismatches;

    function new();
      top_value  = mstb_pkg::MS_TOP_RESET;
      mismatches = 0;
      for (int i = 0; i < mstb_pkg::NUM_TIMERS; i++) clear_timer(i);
    endfunction

    function void clear_timer(int i);
      reserved[i]  = 1'b0;
      running[i]   = 1'b0;
      tmo_store[i] = '0;
      ms_count[i]  = '0;
      prescale[i]  = '0;
    endfunction

    function void restart(int i);
      ms_count[i] = '0;
      prescale[i] = '0;
      running[i]  = 1'b1;
    endfunction

    function timer_reply_t note_command(logic [mstb_pkg::MODE_W-1:0] m,
                                        logic [mstb_pkg::TIMER_W-1:0] sel,
                                        mstb_pkg::time_val_t tmo);
      timer_reply_t r;
      bit           hit;
      r.slot = mstb_pkg::TIMER_NONE;
      r.flag = 1'b0;
      r.ok   = 1'b0;
      hit    = (int'(sel) < mstb_pkg::NUM_TIMERS) && reserved[sel];
      if (m == mstb_pkg::MODE_TICK) begin
        r.ok = 1'b1;
        for (int i = 0; i < mstb_pkg::NUM_TIMERS; i++) begin
          if (reserved[i] && running[i]) begin
            if (prescale[i] == top_value) begin
              prescale[i] = '0;
              if (ms_count[i] != COUNT_MAX) ms_count[i]++;
            end else begin
              prescale[i]++;
            end
          end
        end
      end else if (m == mstb_pkg::MODE_INIT) begin
        if (tmo != '0) begin
          for (int i = 0; i < mstb_pkg::NUM_TIMERS && !r.ok; i++) begin
            if (!reserved[i]) begin
              clear_timer(i);
              reserved[i]  = 1'b1;
              tmo_store[i] = tmo;
              r.slot       = mstb_pkg::TIMER_W'(i);
              r.ok         = 1'b1;
            end
          end
        end
      end else if (hit) begin
        r.ok = 1'b1;
        case (m)
          mstb_pkg::MODE_DEINIT: clear_timer(sel);
          mstb_pkg::MODE_START:  restart(sel);
          mstb_pkg::MODE_STOP:   running[sel] = 1'b0;
          mstb_pkg::MODE_TOGGLE: begin
            if (running[sel]) running[sel] = 1'b0;
            else restart(sel);
          end
          mstb_pkg::MODE_ELAPSED: begin
            if (running[sel] && tmo_store[sel] <= ms_count[sel]) begin
              ms_count[sel] = '0;
              r.flag        = 1'b1;
            end
          end
          default: r.flag = running[sel];
        endcase
      end
      replies_due.push_back(r);
      return r;
    endfunction

    task report_mismatch(string msg);
      if (mismatches < REPORT_LINES) $display("%0t mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_reply(timer_reply_t got);
      timer_reply_t want;
      if (replies_due.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: slot %0d flag %0d ok %0d",
                                  got.slot, got.flag, got.ok));
        return;
      end
      want = replies_due.pop_front();
      if (got.slot !== want.slot)
        report_mismatch($sformatf("assigned_timer %0d, want %0d", got.slot, want.slot));
      if (got.flag !== want.flag)
        report_mismatch($sformatf("answer_flag %0d, want %0d", got.flag, want.flag));
      if (got.ok !== want.ok)
        report_mismatch($sformatf("accepted %0d, want %0d", got.ok, want.ok));
    endtask
  endclass

  logic                         clk;
  logic                         rst           = 1'b1;
  logic                         in_valid      = 1'b0;
  logic                         in_ready;
  logic [mstb_pkg::MODE_W-1:0]  mode          = mstb_pkg::MODE_TICK;
  logic [mstb_pkg::TIMER_W-1:0] timer_select  = '0;
  mstb_pkg::time_val_t          timeout_value = '0;
  logic                         out_valid;
  logic                         out_ready     = 1'b0;
  logic [mstb_pkg::TIMER_W-1:0] assigned_timer;
  logic                         answer_flag;
  logic                         accepted;
  logic                         cfg_valid     = 1'b0;
  logic                         cfg_ready;
  mstb_pkg::time_val_t          cfg_data      = '0;

  int idle_pct   = 0;
  int stall_pct  = 0;
  int items_done = 0;

  timer_bank_shadow shadow = new();

  millisecond_timer_bank DUT (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("** millisecond_timer_bank: FAILED **");
    $finish;
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      shadow.check_reply({assigned_timer, answer_flag, accepted});
  end

  task automatic send_item(input logic [mstb_pkg::MODE_W-1:0] m,
                           input logic [mstb_pkg::TIMER_W-1:0] sel,
                           input mstb_pkg::time_val_t tmo, output timer_reply_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    mode          <= m;
    timer_select  <= sel;
    timeout_value <= tmo;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = shadow.note_command(m, sel, tmo);
    items_done++;
  endtask

  task automatic issue(input logic [mstb_pkg::MODE_W-1:0] m,
                       input logic [mstb_pkg::TIMER_W-1:0] sel,
                       input mstb_pkg::time_val_t tmo);
    timer_reply_t dummy;
    send_item(m, sel, tmo, dummy);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (shadow.replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_top(input mstb_pkg::time_val_t v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow.top_value = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic tick_burst(input int n);
    repeat (n)
      issue(mstb_pkg::MODE_TICK, mstb_pkg::TIMER_W'($urandom), mstb_pkg::TIME_W'($urandom));
  endtask

  task automatic run_sequence();
    timer_reply_t                 r;
    logic [mstb_pkg::TIMER_W-1:0] slot;
    send_item(mstb_pkg::MODE_INIT, mstb_pkg::TIMER_W'($urandom),
              mstb_pkg::TIME_W'($urandom_range(1, 6)), r);
    if (!r.ok) begin
      slot = mstb_pkg::TIMER_W'($urandom_range(mstb_pkg::NUM_TIMERS - 1));
      issue(mstb_pkg::MODE_DEINIT, slot, mstb_pkg::TIME_W'($urandom));
      send_item(mstb_pkg::MODE_INIT, slot, mstb_pkg::TIME_W'($urandom_range(1, 6)), r);
    end
    slot = r.slot;
    issue($urandom_range(1) ? mstb_pkg::MODE_START : mstb_pkg::MODE_TOGGLE, slot,
          mstb_pkg::TIME_W'($urandom));
    tick_burst($urandom_range(24));
    issue(mstb_pkg::MODE_ELAPSED, slot, mstb_pkg::TIME_W'($urandom));
    if ($urandom_range(1)) begin
      tick_burst($urandom_range(8));
      issue(mstb_pkg::MODE_ELAPSED, slot, mstb_pkg::TIME_W'($urandom));
    end
    if ($urandom_range(2) == 0)
      issue(mstb_pkg::MODE_RUNNING, slot, mstb_pkg::TIME_W'($urandom));
    if ($urandom_range(3) == 0)
      issue($urandom_range(1) ? mstb_pkg::MODE_STOP : mstb_pkg::MODE_TOGGLE, slot,
            mstb_pkg::TIME_W'($urandom));
    if ($urandom_range(1)) issue(mstb_pkg::MODE_DEINIT, slot, mstb_pkg::TIME_W'($urandom));
  endtask

  initial begin
    mstb_pkg::time_val_t tmo;
    int                  mark;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: reset top value, then top value zero
    issue(mstb_pkg::MODE_TICK, '0, '0);
    write_top('0);
    issue(mstb_pkg::MODE_ELAPSED, 2'd0, '0);
    issue(mstb_pkg::MODE_INIT, 2'd1, '0);
    issue(mstb_pkg::MODE_INIT, 2'd0, '1);
    issue(mstb_pkg::MODE_INIT, 2'd0, 16'd1);
    issue(mstb_pkg::MODE_INIT, 2'd0, 16'd2);
    issue(mstb_pkg::MODE_INIT, 2'd0, 16'd5);
    issue(mstb_pkg::MODE_START, 2'd1, '0);
    issue(mstb_pkg::MODE_TICK, '1, '1);
    issue(mstb_pkg::MODE_ELAPSED, 2'd1, '0);
    issue(mstb_pkg::MODE_RUNNING, 2'd1, '0);
    issue(mstb_pkg::MODE_TOGGLE, 2'd1, '0);
    issue(mstb_pkg::MODE_RUNNING, 2'd1, '0);
    issue(mstb_pkg::MODE_ELAPSED, 2'd1, '0);
    issue(mstb_pkg::MODE_TOGGLE, 2'd1, '0);
    issue(mstb_pkg::MODE_STOP, 2'd0, '0);
    issue(mstb_pkg::MODE_START, 2'd2, '0);
    tick_burst(2);
    issue(mstb_pkg::MODE_ELAPSED, 2'd2, '0);
    issue(mstb_pkg::MODE_START, mstb_pkg::TIMER_NONE, '1);
    issue(mstb_pkg::MODE_RUNNING, mstb_pkg::TIMER_NONE, '0);
    issue(mstb_pkg::MODE_DEINIT, mstb_pkg::TIMER_NONE, '0);
    issue(mstb_pkg::MODE_DEINIT, 2'd0, '0);
    issue(mstb_pkg::MODE_RUNNING, 2'd0, '0);

    // prescale left above a lowered top value
    write_top(16'd3);
    for (int i = 0; i < mstb_pkg::NUM_TIMERS; i++)
      issue(mstb_pkg::MODE_DEINIT, mstb_pkg::TIMER_W'(i), '0);
    issue(mstb_pkg::MODE_INIT, 2'd0, '1);
    issue(mstb_pkg::MODE_INIT, 2'd0, 16'd1);
    issue(mstb_pkg::MODE_START, 2'd1, '0);
    tick_burst(2);
    write_top('0);
    issue(mstb_pkg::MODE_START, 2'd0, '0);
    tick_burst(40);
    issue(mstb_pkg::MODE_ELAPSED, 2'd0, '0);
    issue(mstb_pkg::MODE_ELAPSED, 2'd1, '0);
    issue(mstb_pkg::MODE_RUNNING, 2'd1, '0);

    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       write_top(16'd1);
        1:       write_top(16'd2);
        2:       write_top('0);
        3:       write_top(COUNT_MAX);
        default: write_top(mstb_pkg::TIME_W'($urandom_range(1, 5)));
      endcase
      case (p % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 67; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      for (int half = 0; half < 2; half++) begin
        mark = items_done;
        while (items_done - mark < 60) begin
          if ($urandom_range(9) < 7) begin
            run_sequence();
          end else begin
            case ($urandom_range(2))
              0:       tmo = '0;
              1:       tmo = mstb_pkg::TIME_W'($urandom_range(1, 6));
              default: tmo = mstb_pkg::TIME_W'($urandom);
            endcase
            issue(mstb_pkg::MODE_W'($urandom), mstb_pkg::TIMER_W'($urandom), tmo);
          end
        end
        // hold the sender until every result is back
        wait_drained();
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (shadow.mismatches == 0)
      $display("** millisecond_timer_bank: PASSED **");
    else
      $display("** millisecond_timer_bank: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/mstb_pkg.sv
hw/rtl/millisecond_timer_bank.sv
bench/millisecond_timer_bank_test.sv
